/* hdl/bba_pkg.sv */
`default_nettype none

package bba_pkg;

   localparam int MAX_BUCKETS_DEF = 256;
   localparam int ADDR_WIDTH_DEF  = 32;

   // fixed field widths
   localparam int FIELD_ADDR_W = 32;
   localparam int SIZE_W       = 16;
   localparam int CNT_FIELD_W  = 9;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int RSP_DATA_W   = 56;

   // largest bitmap row width in the occupancy RAM
   localparam int ROW_BITS_MAX = 32;

   localparam logic [CSR_IDX_W-1:0] REG_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT = 2'd2;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_RANGE    = 3'd2,
      STAT_MISALIGN = 3'd3,
      STAT_NOT_USED = 3'd4
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OFFSET,
      ST_MUL,
      ST_SPAN_CHK,
      ST_DIV,
      ST_ROW_RD,
      ST_ROW_CHK,
      ST_ADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      status_type              status;
      logic [FIELD_ADDR_W-1:0] bucket_address;
      logic [CNT_FIELD_W-1:0]  used_count;
      logic [CNT_FIELD_W-1:0]  free_count;
   } result_type;

endpackage

`default_nettype wire

/* hdl/bba_ram.sv */
`default_nettype none

module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hdl/bba_alu.sv */
`default_nettype none

// shared add / subtract unit; borrow is set when a < b on subtract
module bba_alu #(
   parameter int DW = 48
) (
   input  wire logic [DW-1:0] a,
   input  wire logic [DW-1:0] b,
   input  wire logic          sub,
   output logic      [DW-1:0] y,
   output logic               borrow
);

   logic [DW:0] sum;

   always_comb begin
      if (sub) begin
         sum = {1'b0, a} - {1'b0, b};
      end else begin
         sum = {1'b0, a} + {1'b0, b};
      end
   end

   assign y      = sum[DW-1:0];
   assign borrow = sum[DW];

endmodule

`default_nettype wire

/* hdl/bba_seq.sv */
`default_nettype none

module bba_seq import bba_pkg::*; #(
   parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
   parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
   localparam int CW = $clog2(MAX_BUCKETS + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    clear,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire req_kind_type            req_kind,
   input  wire logic [FIELD_ADDR_W-1:0] req_address,
   input  wire logic [FIELD_ADDR_W-1:0] base,
   input  wire logic [SIZE_W-1:0]       size,
   input  wire logic [CW-1:0]           count,
   output logic                         done,
   input  wire logic                    out_free,
   output result_type                   result
);

   localparam int RW   = (MAX_BUCKETS < ROW_BITS_MAX) ? 2 ** $clog2(MAX_BUCKETS) : ROW_BITS_MAX;
   localparam int BW   = $clog2(RW);
   localparam int ROWS = (MAX_BUCKETS + RW - 1) / RW;
   localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IXW  = $clog2(ROWS * RW);
   localparam int MW   = (CW > IXW) ? CW : IXW;
   localparam int DW   = (ADDR_WIDTH > SIZE_W + MW) ? ADDR_WIDTH : SIZE_W + MW;
   localparam int SCW  = $clog2(MW + 1);

   state_type              state_ff, state_in;
   req_kind_type           kind_ff, kind_in;
   logic [ADDR_WIDTH-1:0]  req_addr_ff, req_addr_in;
   logic [DW-1:0]          ofs_ff, ofs_in;      // offset, then division remainder
   logic [DW-1:0]          acc_ff, acc_in;      // product accumulator
   logic [DW-1:0]          ssh_ff, ssh_in;      // shifted bucket size
   logic [MW-1:0]          mul_ff, mul_in;      // multiplier bits, shifted out
   logic [SCW-1:0]         step_ff, step_in;
   logic [IXW-1:0]         idx_ff, idx_in;
   logic [RAW-1:0]         row_ff, row_in;
   logic [ROWS-1:0]        valid_ff, valid_in;
   logic [CW-1:0]          used_ff, used_in;
   status_type             status_ff, status_in;
   logic [FIELD_ADDR_W-1:0] baddr_ff, baddr_in;

   logic [DW-1:0] alu_a, alu_b, alu_y;
   logic          alu_sub, alu_borrow;

   logic          ram_we;
   logic [RW-1:0] ram_wdata, ram_rdata;

   logic [DW-1:0] base_ext;
   logic [RW-1:0] word, beyond, inv, onehot, set_word, clr_word;
   logic [BW-1:0] bitpos, fbit;
   logic          found, is_used, last_row, pool_full, div_last, mul_last;
   logic [DW-1:0] rem_next;
   logic [IXW-1:0] quo_next, alloc_idx;

   assign base_ext  = DW'(ADDR_WIDTH'(base));
   assign last_row  = (row_ff == RAW'(ROWS - 1));
   assign pool_full = (used_ff >= count);
   assign mul_last  = (step_ff == SCW'(MW - 1));
   assign div_last  = (step_ff == SCW'(IXW - 1));

   bba_alu #(.DW(DW)) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .y      (alu_y),
      .borrow (alu_borrow)
   );

   bba_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (row_ff),
      .wdata (ram_wdata),
      .raddr (row_ff),
      .rdata (ram_rdata)
   );

   // row word; rows never written since the last clear read as all free
   always_comb begin
      word = valid_ff[row_ff] ? ram_rdata : '0;
      for (int b = 0; b < RW; b++) begin
         beyond[b] = (((MW'(row_ff) << BW) | MW'(b)) >= MW'(count));
      end
      inv    = ~(word | beyond);
      onehot = inv & (~inv + RW'(1));
      found  = |inv;
      bitpos = '0;
      for (int b = 0; b < RW; b++) begin
         if (onehot[b]) begin
            bitpos = bitpos | BW'(b);
         end
      end
      fbit      = idx_ff[BW-1:0];
      is_used   = word[fbit];
      set_word  = word | onehot;
      clr_word  = word & ~(RW'(1) << fbit);
      alloc_idx = (IXW'(row_ff) << BW) | IXW'(bitpos);
      rem_next  = alu_borrow ? ofs_ff : alu_y;
      quo_next  = (idx_ff << 1) | IXW'(!alu_borrow);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == REQ_FREE) begin
                  state_in = ST_OFFSET;
               end else if (pool_full) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ROW_RD;
               end
            end
         end
         ST_OFFSET: state_in = ST_MUL;
         ST_MUL: begin
            if (mul_last) begin
               state_in = (kind_ff == REQ_FREE) ? ST_SPAN_CHK : ST_ADD;
            end
         end
         ST_SPAN_CHK: state_in = alu_borrow ? ST_DIV : ST_DONE;
         ST_DIV: begin
            if (div_last) begin
               state_in = (rem_next != '0) ? ST_DONE : ST_ROW_RD;
            end
         end
         ST_ROW_RD: state_in = ST_ROW_CHK;
         ST_ROW_CHK: begin
            if (kind_ff == REQ_FREE) begin
               state_in = ST_DONE;
            end else if (found) begin
               state_in = ST_MUL;
            end else begin
               state_in = last_row ? ST_DONE : ST_ROW_RD;
            end
         end
         ST_ADD: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in     = kind_ff;
      req_addr_in = req_addr_ff;
      ofs_in      = ofs_ff;
      acc_in      = acc_ff;
      ssh_in      = ssh_ff;
      mul_in      = mul_ff;
      step_in     = step_ff;
      idx_in      = idx_ff;
      row_in      = row_ff;
      valid_in    = valid_ff;
      used_in     = used_ff;
      status_in   = status_ff;
      baddr_in    = baddr_ff;
      alu_a       = ofs_ff;
      alu_b       = ssh_ff;
      alu_sub     = 1'b1;
      ram_we      = 1'b0;
      ram_wdata   = set_word;
      req_ready   = 1'b0;
      done        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in     = req_kind;
               req_addr_in = ADDR_WIDTH'(req_address);
               status_in   = STAT_OK;
               baddr_in    = '0;
               row_in      = '0;
               acc_in      = '0;
               ssh_in      = DW'(size);
               mul_in      = MW'(count);
               step_in     = '0;
               if (req_kind == REQ_ALLOC && pool_full) begin
                  status_in = STAT_FULL;
               end
            end
         end
         ST_OFFSET: begin
            alu_a  = DW'(req_addr_ff);
            alu_b  = base_ext;
            ofs_in = DW'(ADDR_WIDTH'(alu_y));
         end
         ST_MUL: begin
            // shift-add: one multiplier bit per cycle
            alu_a   = acc_ff;
            alu_b   = ssh_ff;
            alu_sub = 1'b0;
            if (mul_ff[0]) begin
               acc_in = alu_y;
            end
            ssh_in  = ssh_ff << 1;
            mul_in  = mul_ff >> 1;
            step_in = step_ff + SCW'(1);
         end
         ST_SPAN_CHK: begin
            alu_a   = ofs_ff;
            alu_b   = acc_ff;
            ssh_in  = DW'(size) << (IXW - 1);
            step_in = '0;
            idx_in  = '0;
            if (!alu_borrow) begin
               status_in = STAT_RANGE;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            alu_a   = ofs_ff;
            alu_b   = ssh_ff;
            ofs_in  = rem_next;
            idx_in  = quo_next;
            ssh_in  = ssh_ff >> 1;
            step_in = step_ff + SCW'(1);
            if (div_last) begin
               if (rem_next != '0) begin
                  status_in = STAT_MISALIGN;
               end else begin
                  row_in = RAW'(quo_next >> BW);
               end
            end
         end
         ST_ROW_RD: begin
         end
         ST_ROW_CHK: begin
            if (kind_ff == REQ_FREE) begin
               if (is_used) begin
                  ram_we           = 1'b1;
                  ram_wdata        = clr_word;
                  valid_in[row_ff] = 1'b1;
                  if (used_ff != '0) begin
                     used_in = used_ff - CW'(1);
                  end
               end else begin
                  status_in = STAT_NOT_USED;
               end
            end else if (found) begin
               ram_we           = 1'b1;
               ram_wdata        = set_word;
               valid_in[row_ff] = 1'b1;
               idx_in           = alloc_idx;
               used_in          = used_ff + CW'(1);
               acc_in           = '0;
               ssh_in           = DW'(size);
               mul_in           = MW'(alloc_idx);
               step_in          = '0;
            end else if (last_row) begin
               status_in = STAT_FULL;
            end else begin
               row_in = row_ff + RAW'(1);
            end
         end
         ST_ADD: begin
            alu_a    = base_ext;
            alu_b    = acc_ff;
            alu_sub  = 1'b0;
            baddr_in = FIELD_ADDR_W'(ADDR_WIDTH'(alu_y));
         end
         ST_DONE: begin
            done = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.status         = status_ff;
      result.bucket_address = baddr_ff;
      result.used_count     = CNT_FIELD_W'(used_ff);
      result.free_count     = (count >= used_ff) ? CNT_FIELD_W'(count - used_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (reset || clear) begin
         valid_ff <= '0;
         used_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
      end
      kind_ff     <= kind_in;
      req_addr_ff <= req_addr_in;
      ofs_ff      <= ofs_in;
      acc_ff      <= acc_in;
      ssh_ff      <= ssh_in;
      mul_ff      <= mul_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      row_ff      <= row_in;
      status_ff   <= status_in;
      baddr_ff    <= baddr_in;
   end

endmodule

`default_nettype wire

/* hdl/bitmap_block_allocator.sv */
// Fixed-size block allocator over an occupancy bitmap. An allocate item takes
// the lowest free bucket below bucket_count, marks it used and returns
// base_address + index * bucket_size; a free item checks, in this order, that
// the address lies inside the pool (offset from the base below
// bucket_count * bucket_size, modulo 2^ADDR_WIDTH), sits on a bucket boundary
// and names a used bucket, then clears its mark. Every result carries the used
// and free counts after the item. The bitmap lives in a RAM of rows of up to 32
// bits with one valid flop per row, so reset and a bucket_count write empty the
// pool at once, with no clearing pass. One shared add/subtract unit does all
// address math under a small sequencer, and the block takes one item at a time.
// Steps at the defaults (256 buckets): an allocate reads and checks each bitmap
// row scanned (up to 8 rows), then runs 9 multiply steps, one add and a result
// state; a full pool goes straight to its result. A free runs one subtract,
// 9 shift-add steps for the pool span and one compare (an address out of range
// ends here), 8 restoring division steps for the index (a misaligned address
// ends here), one RAM read, one check and its result. In general the multiply
// takes clog2(MAX_BUCKETS+1) steps and the division clog2 of the bitmap size.
// A stalled result holds the sequencer in its result state. Zero bucket_size
// acts as 1; bucket_count above MAX_BUCKETS is clamped. Writing bucket_count
// restarts the pool; writing base or size keeps the bitmap. Configuration must
// be written only while idle; the block itself does not enforce this.
`default_nettype none

module bitmap_block_allocator import bba_pkg::*; #(
   parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
   parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [FIELD_ADDR_W-1:0] req_tdata,   // [31:0] free_address
   input  wire logic                    req_tuser,   // [0] req_type

   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [2:0] status, [34:3] bucket_address, [43:35] used_count,
   // [52:44] free_count, [55:53] zero
   output logic      [RSP_DATA_W-1:0]   rsp_tdata,

   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW   = $clog2(MAX_BUCKETS + 1);
   localparam int CNTW = (CW > CNT_FIELD_W) ? CW : CNT_FIELD_W;

   // configuration registers
   logic [FIELD_ADDR_W-1:0] base_ff;
   logic [SIZE_W-1:0]       size_ff;
   logic [CNT_FIELD_W-1:0]  count_ff;
   logic                    pool_clear;

   // effective values seen by the sequencer
   logic [SIZE_W-1:0]       size_eff;
   logic [CNTW-1:0]         count_ext;
   logic [CW-1:0]           count_sat;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic       seq_done;
   logic       out_free;
   result_type seq_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         size_ff  <= SIZE_W'(1);
         count_ff <= CNT_FIELD_W'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_BASE:  base_ff  <= csr_wdata;
            REG_SIZE:  size_ff  <= csr_wdata[SIZE_W-1:0];
            REG_COUNT: count_ff <= csr_wdata[CNT_FIELD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // a bucket_count write restarts the pool
   assign pool_clear = csr_we && (csr_index == REG_COUNT);

   assign size_eff  = (size_ff == '0) ? SIZE_W'(1) : size_ff;
   assign count_ext = CNTW'(count_ff);
   assign count_sat = (count_ext > CNTW'(MAX_BUCKETS)) ? CW'(MAX_BUCKETS) : CW'(count_ext);

   bba_seq #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .ADDR_WIDTH  (ADDR_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .clear       (pool_clear),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_kind_type'(req_tuser)),
      .req_address (req_tdata),
      .base        (base_ff),
      .size        (size_eff),
      .count       (count_sat),
      .done        (seq_done),
      .out_free    (out_free),
      .result      (seq_result)
   );

   // the sequencer hands over a result only when the output slot is free
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, seq_result.free_count, seq_result.used_count,
                         seq_result.bucket_address, seq_result.status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* hdl/bba_checker.sv */
`default_nettype none

module bba_checker import bba_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   // a full pool leaves nothing free
   a_full_no_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == STAT_FULL) |-> (rsp_tdata[52:44] == '0))
      else $error("pool full with free buckets");

   // only a good allocate carries an address
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != STAT_OK) |-> (rsp_tdata[34:3] == '0))
      else $error("failed item carries an address");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire

/* sim/bitmap_block_allocator_test.sv */
`default_nettype none

module bitmap_block_allocator_test;
   import bba_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // index with no register behind it, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 2'd3;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
   localparam int PHASE_ITEMS  = 150;
   localparam int PHASES       = 12;
   localparam int SETTLE       = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid;
   logic                    req_tready;
   logic [FIELD_ADDR_W-1:0] req_tdata;    // [31:0] free_address
   logic                    req_tuser;    // [0] req_type

   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // [2:0] status, [34:3] bucket_address, [43:35] used_count, [52:44] free_count
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // shadow of the allocator: registers, occupancy bitmap, used total
   logic [31:0]                pool_base  = '0;
   logic [15:0]                pool_size  = 16'd1;
   logic [8:0]                 pool_count = 9'd256;
   bit   [MAX_BUCKETS_DEF-1:0] pool_map   = '0;
   int unsigned                pool_used  = 0;

   result_type pending[$];        // responses owed, oldest first
   int         items_sent      = 0;
   int         results_checked = 0;
   int         mismatches      = 0;
   int         cycle_count     = 0;

   // traffic shaping knobs
   bit source_gaps_on   = 1'b0;
   bit sink_gaps_on     = 1'b0;
   int long_holds_asked = 0;
   int long_holds_taken = 0;
   int sink_wait        = 0;

   bitmap_block_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL bitmap_block_allocator");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // count above the bitmap size clamps
   function automatic int unsigned live_buckets();
      return (pool_count > MAX_BUCKETS_DEF) ? MAX_BUCKETS_DEF : pool_count;
   endfunction

   // zero size behaves as one
   function automatic int unsigned live_step();
      return (pool_size == 16'd0) ? 1 : pool_size;
   endfunction

   // Expected response for one request; also advances the shadow bitmap.
   function automatic result_type predict_response(req_kind_type kind,
                                                   logic [31:0] address);
      result_type      r;
      int unsigned     live;
      int unsigned     slot;
      longint unsigned step;
      longint unsigned offset;
      longint unsigned span;
      logic [31:0]     delta;
      bit              found;
      live = live_buckets();
      step = live_step();
      r.status         = STAT_OK;
      r.bucket_address = '0;
      found            = 1'b0;
      if (kind == REQ_ALLOC) begin
         for (slot = 0; slot < live && !found; slot++) begin
            if (!pool_map[slot]) begin
               found = 1'b1;
               pool_map[slot] = 1'b1;
               pool_used++;
               r.bucket_address = pool_base + 32'(slot * step);
            end
         end
         if (!found)
            r.status = STAT_FULL;
      end else begin
         // offset wraps mod 2^32, so below-base lands far out of range
         delta  = address - pool_base;
         offset = 64'(delta);
         span   = live * step;
         if (offset >= span)
            r.status = STAT_RANGE;
         else if (offset % step != 0)
            r.status = STAT_MISALIGN;
         else begin
            slot = 32'(offset / step);
            if (!pool_map[slot])
               r.status = STAT_NOT_USED;
            else begin
               pool_map[slot] = 1'b0;
               pool_used--;
            end
         end
      end
      r.used_count = CNT_FIELD_W'(pool_used);
      r.free_count = (live >= pool_used) ? CNT_FIELD_W'(live - pool_used) : '0;
      return r;
   endfunction

   // random used bucket, or -1 when the pool is empty
   function automatic int find_used_slot();
      int unsigned live;
      int unsigned first;
      int unsigned k;
      int          hit;
      live = live_buckets();
      hit  = -1;
      if (live != 0) begin
         first = $urandom_range(0, live - 1);
         for (k = 0; k < live && hit < 0; k++)
            if (pool_map[(first + k) % live])
               hit = (first + k) % live;
      end
      return hit;
   endfunction

   // Free targets: mostly live buckets, the rest boundaries, misaligned,
   // pool edges and plain noise.
   function automatic logic [31:0] choose_free_address();
      int unsigned live;
      int unsigned step;
      int          slot;
      int          roll;
      live = live_buckets();
      step = live_step();
      roll = $urandom_range(0, 99);
      if (live != 0 && roll < 55) begin
         slot = find_used_slot();
         if (slot < 0)
            slot = $urandom_range(0, live - 1);
         return pool_base + 32'(slot * step);
      end else if (live != 0 && roll < 70) begin
         return pool_base + 32'($urandom_range(0, live - 1) * step);
      end else if (live != 0 && roll < 80) begin
         return pool_base + 32'($urandom_range(0, live - 1) * step)
                + 32'($urandom_range(0, step - 1));
      end else if (roll < 90) begin
         case ($urandom_range(0, 2))
            0:       return pool_base + 32'(live * step);        // pool end
            1:       return pool_base - 32'd1;                   // just below base
            default: return pool_base + 32'(live * step) - 32'd1;
         endcase
      end
      return $urandom();
   endfunction

   // one request item; tvalid stays up so back-to-back items need no drop
   task automatic send_request(input req_kind_type kind, input logic [31:0] address);
      int gap;
      gap = source_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= address;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending.push_back(predict_response(kind, address));
      items_sent++;
   endtask

   task automatic allocate();
      send_request(REQ_ALLOC, $urandom());   // address is don't-care here
   endtask

   task automatic release_at(input logic [31:0] address);
      send_request(REQ_FREE, address);
   endtask

   // sender pause until every owed response has been checked
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (results_checked != items_sent) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_BASE: pool_base = value;
         REG_SIZE: pool_size = value[15:0];
         REG_COUNT: begin
            // count write restarts the pool
            pool_count = value[8:0];
            pool_map   = '0;
            pool_used  = 0;
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   // receiver: random stalls plus the occasional long hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (sink_wait != 0) begin
         rsp_tready <= 1'b0;
         sink_wait  <= sink_wait - 1;
      end else if (long_holds_taken != long_holds_asked) begin
         long_holds_taken <= long_holds_taken + 1;
         sink_wait        <= LONG_HOLD;
         rsp_tready       <= 1'b0;
      end else if (sink_gaps_on && $urandom_range(0, 7) == 0) begin
         sink_wait  <= pick_gap();
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= 1'b1;
   end

   // response checker, in order against the oldest owed response
   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked <= results_checked + 1;
         if (pending.size() == 0) begin
            $error("response item with nothing outstanding: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending.pop_front();
            if (rsp_tdata[2:0] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[2:0]);
               mismatches++;
            end
            if (rsp_tdata[34:3] !== want.bucket_address) begin
               $error("bucket_address: expected %h, actual %h",
                      want.bucket_address, rsp_tdata[34:3]);
               mismatches++;
            end
            if (rsp_tdata[43:35] !== want.used_count) begin
               $error("used_count: expected %0d, actual %0d",
                      want.used_count, rsp_tdata[43:35]);
               mismatches++;
            end
            if (rsp_tdata[52:44] !== want.free_count) begin
               $error("free_count: expected %0d, actual %0d",
                      want.free_count, rsp_tdata[52:44]);
               mismatches++;
            end
         end
      end
   end

   // Reset values: base 0, unit buckets, all 256 buckets live.
   task automatic test_default_pool();
      repeat (3) allocate();            // buckets 0..2
      release_at(32'd1);                // ok
      release_at(32'd1);                // already free
      release_at(32'd256);              // exactly at pool end
      release_at(32'hFFFF_FFFF);        // far out
      allocate();                       // lowest free is bucket 1 again
      wait_for_results();
   endtask

   // Three 8-unit buckets straddling the top of the address space.
   task automatic test_wrapped_pool();
      write_register(REG_COUNT, 32'hFFFF_FE03);   // upper bits must be dropped
      write_register(REG_SIZE,  32'hA5A5_0008);
      write_register(REG_BASE,  32'hFFFF_FFF0);
      write_register(REG_NONE,  32'h5A5A_5A5A);   // no such register
      repeat (3) allocate();            // F0, F8, wrapped 00
      allocate();                       // pool full
      release_at(32'h0000_0000);        // free by wrapped address
      release_at(32'hFFFF_FFF4);        // mid-bucket
      release_at(32'hFFFF_FFE8);        // below base
      release_at(32'h0000_0008);        // pool end after wrap
      wait_for_results();
      // size 0 acts as 1, bitmap kept: bucket 1 now sits at F1
      write_register(REG_SIZE, 32'h0000_0000);
      release_at(32'hFFFF_FFF1);
      wait_for_results();
   endtask

   // Empty pool, then a count over the limit with the widest buckets.
   task automatic test_empty_and_saturated_pool();
      write_register(REG_COUNT, 32'h0000_0000);
      allocate();                       // full
      release_at(pool_base);            // out of range
      wait_for_results();
      write_register(REG_COUNT, 32'h0000_01FF);   // clamps to 256
      write_register(REG_SIZE,  32'h0000_FFFF);
      write_register(REG_BASE,  32'h0000_0000);
      allocate();
      release_at(32'h0000_FFFF);        // bucket 1, never used
      release_at(32'h00FF_FF00);        // 256 * 65535, pool end
      release_at(32'h00FE_FF01);        // last bucket, never used
      wait_for_results();
   endtask

   // Block fills while the receiver holds off; sender keeps pushing.
   task automatic test_backpressure();
      write_register(REG_COUNT, 32'd8);
      write_register(REG_SIZE,  32'd4);
      write_register(REG_BASE,  $urandom());
      source_gaps_on = 1'b0;
      sink_gaps_on     <= 1'b0;
      long_holds_asked <= long_holds_asked + 1;
      repeat (24) begin
         if ($urandom_range(0, 1) == 0)
            allocate();
         else
            release_at(choose_free_address());
      end
      wait_for_results();
   endtask

   // Phases of random traffic, each under its own configuration.
   task automatic test_random_traffic();
      int          phase;
      int          n;
      int unsigned alloc_pct;
      logic [31:0] noise;
      for (phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         source_gaps_on = (phase % 3) != 0;
         sink_gaps_on <= (phase % 4) != 1;
         noise = $urandom();
         case (phase % 6)
            0: begin
               write_register(REG_COUNT, {noise[31:9], 9'd256});
               write_register(REG_SIZE,  {noise[31:16], 16'd1});
               write_register(REG_BASE,  32'h0000_0000);
            end
            1: begin
               write_register(REG_COUNT, 32'd256);
               write_register(REG_SIZE,  32'h0000_FFFF);
               write_register(REG_BASE,  $urandom() | 32'hFF00_0000);
            end
            2: begin
               write_register(REG_COUNT, $urandom_range(1, 8));
               write_register(REG_SIZE,  {noise[31:16], 16'($urandom_range(1, 16))});
               write_register(REG_BASE,  $urandom());
            end
            3: begin
               write_register(REG_COUNT, 32'd1);
               write_register(REG_SIZE,  {noise[31:16], 16'd0});
               write_register(REG_BASE,  $urandom());
            end
            4: begin
               write_register(REG_COUNT, {noise[31:9], 9'($urandom_range(257, 511))});
               write_register(REG_SIZE,  $urandom());
               write_register(REG_BASE,  $urandom());
            end
            default: begin
               write_register(REG_COUNT, $urandom_range(0, 256));
               write_register(REG_SIZE,  $urandom());
               write_register(REG_BASE,  32'hFFFF_FFFF);
            end
         endcase
         alloc_pct = $urandom_range(25, 75);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               // mid-phase: drain, then move the pool under live buckets
               wait_for_results();
               if (phase % 2 == 1)
                  write_register(REG_SIZE, $urandom_range(0, 24));
               else
                  write_register(REG_BASE, $urandom());
               alloc_pct = 100 - alloc_pct;
            end
            if ($urandom_range(0, 99) < alloc_pct)
               allocate();
            else
               release_at(choose_free_address());
         end
      end
      wait_for_results();
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = REG_BASE;
      csr_wdata  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_pool();
      test_wrapped_pool();
      test_empty_and_saturated_pool();
      test_backpressure();
      test_random_traffic();

      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("PASS bitmap_block_allocator");
      else
         $display("FAIL bitmap_block_allocator");
      $finish;
   end

endmodule

`default_nettype wire
